// File: hw/rtl/sdrcr_pkg.sv
// ----------------------------------------------------------------------------
// sdrcr_pkg
// Shared types, register indexes, masks, reset values and the geometry
// size table of the SDRAM controller register file.
// ----------------------------------------------------------------------------
`default_nettype none

package sdrcr_pkg;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  // word indexes within the controller block
  localparam logic [2:0] IDX_INIT        = 3'd0;
  localparam logic [2:0] IDX_TIMING      = 3'd1;
  localparam logic [2:0] IDX_REFRESH     = 3'd2;
  localparam logic [2:0] IDX_APPLICATION = 3'd4;

  // writable masks, cut to the stored widths
  localparam logic [4:0]  MASK_INIT        = 5'h17;
  localparam logic [13:0] MASK_TIMING      = 14'h37f7;
  localparam logic [24:0] MASK_REFRESH     = 25'h1ff0fff;
  localparam logic [31:0] MASK_APPLICATION = 32'h8000003f;

  // reset values
  localparam logic [4:0]  INIT_RESET        = 5'h00;
  localparam logic [13:0] TIMING_RESET      = 14'h00e0;
  localparam logic [24:0] REFRESH_RESET     = 25'h07f008c;
  localparam logic [31:0] APPLICATION_RESET = 32'h00000008;

  // bit positions
  localparam int unsigned BIT_ENABLE      = 4;
  localparam int unsigned BIT_INITIALIZED = 3;
  localparam int unsigned BIT_MRS         = 2;
  localparam int unsigned BIT_APP_ON      = 1;
  localparam int unsigned BIT_SR_ENABLE   = 23;
  localparam int unsigned BIT_SR_STATUS   = 25;

  // bytes of sdram for each geometry code: banks x rows x cols x 2
  function automatic logic [26:0] geometry_bytes(input logic [2:0] geo);
    logic [26:0] bytes;
    unique case (geo)
      3'd0: bytes = 27'd1 << 21;
      3'd1: bytes = 27'd1 << 23;
      3'd2: bytes = 27'd1 << 24;
      3'd3: bytes = 27'd1 << 25;
      3'd4: bytes = 27'd1 << 22;
      3'd5: bytes = 27'd1 << 24;
      3'd6: bytes = 27'd1 << 25;
      3'd7: bytes = 27'd1 << 26;
      default: bytes = '0;
    endcase
    return bytes;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sdrcr_if.sv
// ----------------------------------------------------------------------------
// sdrcr_in_if / sdrcr_out_if
// Valid/ready channels carrying bus accesses in and access results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdrcr_in_if;
  logic                 valid;
  logic                 ready;
  sdrcr_pkg::opcode_t   opcode;
  logic [2:0]           reg_index;
  logic [31:0]          write_data;

  modport source (output valid, output opcode, output reg_index, output write_data,
                  input ready);
  modport sink   (input valid, input opcode, input reg_index, input write_data,
                  output ready);
endinterface

interface sdrcr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        claimed;
  logic [26:0] memory_bytes;
  logic [2:0]  precharge_clocks;
  logic [3:0]  active_clocks;
  logic [4:0]  cycle_clocks;
  logic [1:0]  cas_latency;

  modport source (output valid, output read_data, output claimed, output memory_bytes,
                  output precharge_clocks, output active_clocks, output cycle_clocks,
                  output cas_latency, input ready);
  modport sink   (input valid, input read_data, input claimed, input memory_bytes,
                  input precharge_clocks, input active_clocks, input cycle_clocks,
                  input cas_latency, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sdram_controller_registers_core.sv
// ----------------------------------------------------------------------------
// sdram_controller_registers_core
// Register file of an SDRAM controller: init, timing, refresh and
// application registers, with status merge and timing/size decode.
// ----------------------------------------------------------------------------
// Each bus access is taken into an input register and decoded, and it is
// applied to the register file as it moves on and its result lands in an
// output register. An item moves on only while the output register is empty
// or its result is taken, so one item is accepted every cycle while results
// are taken. The input register accepts one further item while a finished
// result waits on the output side.
// Writes store through each register's writable mask; reads merge the
// initialized flag (init bit 3) and the self-refresh status (refresh bit 25).
// Decoded timings, CAS latency and memory size reflect the state after the
// access. Words at or above REGISTER_WORDS are not claimed.
// ----------------------------------------------------------------------------
`default_nettype none

module sdram_controller_registers_core #(
  parameter int unsigned REGISTER_WORDS = 5
) (
  input  wire              clk,
  input  wire              rst_n,
  sdrcr_in_if.sink         in_chan,
  sdrcr_out_if.source      out_chan
);

  // input register
  logic                 s1_valid_r;
  sdrcr_pkg::opcode_t   s1_opcode_r;
  logic [2:0]           s1_index_r;
  logic [31:0]          s1_data_r;

  // register file
  logic [4:0]  init_r,        init_nxt;
  logic [13:0] timing_r,      timing_nxt;
  logic [24:0] refresh_r,     refresh_nxt;
  logic [31:0] application_r, application_nxt;
  logic        init_flag_r,   init_flag_nxt;

  // result register
  logic        out_valid_r;
  logic [31:0] read_data_r;
  logic        claimed_r;
  logic [26:0] memory_bytes_r;
  logic [2:0]  precharge_r;
  logic [3:0]  active_r;
  logic [4:0]  cycle_r;
  logic [1:0]  cas_r;

  logic        advance;
  logic        s1_claimed;
  logic [31:0] read_data_nxt;
  logic [1:0]  cas_code;

  assign advance      = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign s1_claimed   = {1'b0, s1_index_r} < 4'(REGISTER_WORDS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      s1_opcode_r <= in_chan.opcode;
      s1_index_r  <= in_chan.reg_index;
      s1_data_r   <= in_chan.write_data;
    end
  end

  // register update and read mux
  always_comb begin
    init_nxt        = init_r;
    timing_nxt      = timing_r;
    refresh_nxt     = refresh_r;
    application_nxt = application_r;
    init_flag_nxt   = init_flag_r;
    read_data_nxt   = '0;
    if (s1_claimed) begin
      if (s1_opcode_r == sdrcr_pkg::OP_WRITE) begin
        unique case (s1_index_r)
          sdrcr_pkg::IDX_INIT: begin
            init_nxt = s1_data_r[4:0] & sdrcr_pkg::MASK_INIT;
            if (!s1_data_r[sdrcr_pkg::BIT_ENABLE]) begin
              init_flag_nxt = 1'b0;
            end else if (s1_data_r[sdrcr_pkg::BIT_MRS]) begin
              init_flag_nxt = 1'b1;
            end
          end
          sdrcr_pkg::IDX_TIMING:      timing_nxt = s1_data_r[13:0] & sdrcr_pkg::MASK_TIMING;
          sdrcr_pkg::IDX_REFRESH:     refresh_nxt = s1_data_r[24:0] & sdrcr_pkg::MASK_REFRESH;
          sdrcr_pkg::IDX_APPLICATION: application_nxt = s1_data_r & sdrcr_pkg::MASK_APPLICATION;
          default: ;
        endcase
      end else begin
        unique case (s1_index_r)
          sdrcr_pkg::IDX_INIT: begin
            read_data_nxt = {27'd0, init_r};
            read_data_nxt[sdrcr_pkg::BIT_INITIALIZED] = init_flag_r;
          end
          sdrcr_pkg::IDX_TIMING: read_data_nxt = {18'd0, timing_r};
          sdrcr_pkg::IDX_REFRESH: begin
            read_data_nxt = {7'd0, refresh_r};
            // self-refresh status mirrors its enable
            read_data_nxt[sdrcr_pkg::BIT_SR_STATUS] = refresh_r[sdrcr_pkg::BIT_SR_ENABLE];
          end
          sdrcr_pkg::IDX_APPLICATION: read_data_nxt = application_r;
          default: ;
        endcase
      end
    end
  end

  assign cas_code = application_nxt[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r        <= sdrcr_pkg::INIT_RESET;
      timing_r      <= sdrcr_pkg::TIMING_RESET;
      refresh_r     <= sdrcr_pkg::REFRESH_RESET;
      application_r <= sdrcr_pkg::APPLICATION_RESET;
      init_flag_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (advance) begin
        init_r        <= init_nxt;
        timing_r      <= timing_nxt;
        refresh_r     <= refresh_nxt;
        application_r <= application_nxt;
        init_flag_r   <= init_flag_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      read_data_r <= read_data_nxt;
      claimed_r   <= s1_claimed;
      memory_bytes_r <= (init_flag_nxt && init_nxt[sdrcr_pkg::BIT_ENABLE] &&
                         application_nxt[sdrcr_pkg::BIT_APP_ON]) ?
                        sdrcr_pkg::geometry_bytes(timing_nxt[2:0]) : '0;
      precharge_r <= {1'b0, timing_nxt[13:12]} + 3'd1;
      active_r    <= {1'b0, timing_nxt[10:8]} + 4'd1;
      cycle_r     <= {1'b0, timing_nxt[7:4]} + 5'd1;
      cas_r       <= (cas_code == 2'd0) ? 2'd2 : cas_code;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.read_data        = read_data_r;
  assign out_chan.claimed          = claimed_r;
  assign out_chan.memory_bytes     = memory_bytes_r;
  assign out_chan.precharge_clocks = precharge_r;
  assign out_chan.active_clocks    = active_r;
  assign out_chan.cycle_clocks     = cycle_r;
  assign out_chan.cas_latency      = cas_r;

  // an init write with enable off always drops the initialized flag
  a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_claimed && s1_opcode_r == sdrcr_pkg::OP_WRITE &&
    s1_index_r == sdrcr_pkg::IDX_INIT && !s1_data_r[sdrcr_pkg::BIT_ENABLE]
    |=> !init_flag_r)
    else $error("initialized flag survived an init write with enable off");

  // a reported size agrees with the state that produced it
  a_size_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && memory_bytes_r != '0 |->
    init_flag_r && init_r[sdrcr_pkg::BIT_ENABLE] && application_r[sdrcr_pkg::BIT_APP_ON])
    else $error("memory size reported while controller not ready");

  a_size_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(memory_bytes_r))
    else $error("memory size is not a power of two");

  // the register file only changes when an item moves on
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(init_flag_r) && $stable(timing_r) && $stable(application_r))
    else $error("register file changed without an access");

  a_cas_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> cas_r != 2'd0)
    else $error("reserved cas latency code reported");

endmodule

`default_nettype wire
